// ----- design/cgpr_pkg.sv -----
// Shared types, constants and helpers for the character glyph pixel renderer.
package cgpr_pkg;

    localparam int unsigned COORD_W     = 16;
    localparam int unsigned COLOR_W     = 16;
    localparam int unsigned GLYPH_W     = 6;
    localparam int unsigned ROW_W       = 3;
    localparam int unsigned COL_W       = 3;
    localparam int unsigned CFG_IDX_W   = 4;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [GLYPH_W-1:0] GLYPH_DIGIT_BASE = 6'd26;
    localparam logic [GLYPH_W-1:0] GLYPH_BLANK      = 6'd36;
    localparam logic [ROW_W-1:0]   ROW_LAST         = 3'd7;
    localparam logic [COL_W-1:0]   COL_LAST         = 3'd6;
    localparam logic [COORD_W-1:0] WIN_X_SPAN       = 16'd6;
    localparam logic [COORD_W-1:0] WIN_Y_SPAN       = 16'd7;

    localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 4'd1;

    localparam logic [COLOR_W-1:0] FOREGROUND_RESET = 16'hFFFF;
    localparam logic [COLOR_W-1:0] BACKGROUND_RESET = 16'h0000;

    localparam logic KIND_WINDOW = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_WINDOW,
        SEQ_PIXEL
    } seq_state_t;

    typedef struct packed {
        logic [7:0]         char_code;
        logic [COORD_W-1:0] x_pos;
        logic [COORD_W-1:0] y_pos;
    } in_item_t;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] win_x_start;
        logic [COORD_W-1:0] win_y_start;
        logic [COORD_W-1:0] win_x_end;
        logic [COORD_W-1:0] win_y_end;
        logic [COLOR_W-1:0] pixel_color;
        logic               last;
    } out_item_t;

    // Font memory read request from the sequencer.
    typedef struct packed {
        logic               rd_en;
        logic [GLYPH_W-1:0] glyph;
        logic [ROW_W-1:0]   row;
    } rom_req_t;

    // A-Z -> 0..25, 0-9 -> 26..35, anything else -> blank glyph.
    function automatic logic [GLYPH_W-1:0] map_code(input logic [7:0] code);
        logic [7:0] off;
        begin
            off = 8'd0;
            if (code >= 8'h41 && code <= 8'h5A)
            begin
                off = code - 8'h41;
                map_code = off[GLYPH_W-1:0];
            end
            else if (code >= 8'h30 && code <= 8'h39)
            begin
                off = code - 8'h30;
                map_code = GLYPH_DIGIT_BASE + off[GLYPH_W-1:0];
            end
            else
            begin
                map_code = GLYPH_BLANK;
            end
        end
    endfunction

endpackage

// ----- design/cgpr_font_rom.sv -----
// Font memory: 37 glyphs of 8 rows, one row read per request, registered data.
module cgpr_font_rom
    import cgpr_pkg::*;
(
    input  logic     clk,
    input  rom_req_t req,
    output logic [7:0] rd_data
);

    // Rows packed MSB first: row 0 is bits 63:56, each byte uses bits 6..0.
    function automatic logic [63:0] font_glyph(input logic [GLYPH_W-1:0] glyph);
        begin
            case (glyph)
                6'd0:    font_glyph = 64'h1C22_2222_3E22_2200; // A
                6'd1:    font_glyph = 64'h3C22_223C_2222_3C00; // B
                6'd2:    font_glyph = 64'h1C22_2020_2022_1C00; // C
                6'd3:    font_glyph = 64'h3824_2222_2224_3800; // D
                6'd4:    font_glyph = 64'h3E20_203C_2020_3E00; // E
                6'd5:    font_glyph = 64'h3E20_203C_2020_2000; // F
                6'd6:    font_glyph = 64'h1C22_202E_2222_1E00; // G
                6'd7:    font_glyph = 64'h2222_223E_2222_2200; // H
                6'd8:    font_glyph = 64'h1C08_0808_0808_1C00; // I
                6'd9:    font_glyph = 64'h0E04_0404_0424_1800; // J
                6'd10:   font_glyph = 64'h2224_2830_2824_2200; // K
                6'd11:   font_glyph = 64'h2020_2020_2020_3E00; // L
                6'd12:   font_glyph = 64'h2236_2A2A_2222_2200; // M
                6'd13:   font_glyph = 64'h2222_322A_2622_2200; // N
                6'd14:   font_glyph = 64'h1C22_2222_2222_1C00; // O
                6'd15:   font_glyph = 64'h3C22_223C_2020_2000; // P
                6'd16:   font_glyph = 64'h1C22_2222_2A24_1A00; // Q
                6'd17:   font_glyph = 64'h3C22_223C_2824_2200; // R
                6'd18:   font_glyph = 64'h1E20_201C_0202_3C00; // S
                6'd19:   font_glyph = 64'h3E08_0808_0808_0800; // T
                6'd20:   font_glyph = 64'h2222_2222_2222_1C00; // U
                6'd21:   font_glyph = 64'h2222_2222_2214_0800; // V
                6'd22:   font_glyph = 64'h2222_222A_2A2A_1400; // W
                6'd23:   font_glyph = 64'h2222_1408_1422_2200; // X
                6'd24:   font_glyph = 64'h2222_2214_0808_0800; // Y
                6'd25:   font_glyph = 64'h3E02_0408_1020_3E00; // Z
                6'd26:   font_glyph = 64'h1C22_262A_3222_1C00; // 0
                6'd27:   font_glyph = 64'h0818_0808_0808_1C00; // 1
                6'd28:   font_glyph = 64'h1C22_0204_0810_3E00; // 2
                6'd29:   font_glyph = 64'h3E04_0804_0222_1C00; // 3
                6'd30:   font_glyph = 64'h040C_1424_3E04_0400; // 4
                6'd31:   font_glyph = 64'h3E20_3C02_0222_1C00; // 5
                6'd32:   font_glyph = 64'h0C10_203C_2222_1C00; // 6
                6'd33:   font_glyph = 64'h3E22_0204_0808_0800; // 7
                6'd34:   font_glyph = 64'h1C22_221C_2222_1C00; // 8
                6'd35:   font_glyph = 64'h1C22_221E_0204_1800; // 9
                default: font_glyph = 64'h0;                   // blank
            endcase
        end
    endfunction

    logic [63:0] glyph_rows;
    logic [7:0]  rd_data_reg;

    assign glyph_rows = font_glyph(req.glyph);

    // Data holds between reads, so a stalled row stays put.
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= glyph_rows[{ROW_LAST - req.row, 3'b000} +: 8];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/cgpr_seq.sv -----
// Character sequencer: window item, then 56 pixel items from font rows.
module cgpr_seq
    import cgpr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_item_t           in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output out_item_t          out_item,
    input  logic [COLOR_W-1:0] fg_color,
    input  logic [COLOR_W-1:0] bg_color,
    output rom_req_t           rom_req,
    input  logic [7:0]         rom_data
);

    seq_state_t         state_reg,     state_next;
    logic [GLYPH_W-1:0] glyph_reg,     glyph_next;
    logic [ROW_W-1:0]   row_reg,       row_next;
    logic [COL_W-1:0]   col_reg,       col_next;
    logic [COORD_W-1:0] x_reg,         x_next;
    logic [COORD_W-1:0] y_reg,         y_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_item_reg,  out_item_next;
    logic               out_free;
    logic               pix_on;
    logic [COL_W-1:0]   bit_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            glyph_reg     <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            glyph_reg     <= glyph_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        out_item_reg <= out_item_next;
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign bit_sel  = COL_LAST - col_reg;
    assign pix_on   = rom_data[bit_sel];

    always_comb
    begin
        state_next     = state_reg;
        glyph_next     = glyph_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && out_stall;
        rom_req.rd_en  = 1'b0;
        rom_req.glyph  = glyph_reg;
        rom_req.row    = row_reg + 3'd1;

        case (state_reg)
            SEQ_IDLE:
            begin
                if (in_valid)
                begin
                    glyph_next = map_code(in_item.char_code);
                    x_next     = in_item.x_pos;
                    y_next     = in_item.y_pos;
                    state_next = SEQ_WINDOW;
                end
            end
            SEQ_WINDOW:
            begin
                if (out_free)
                begin
                    out_item_next             = '0;
                    out_item_next.kind        = KIND_WINDOW;
                    out_item_next.win_x_start = x_reg;
                    out_item_next.win_y_start = y_reg;
                    out_item_next.win_x_end   = x_reg + WIN_X_SPAN;
                    out_item_next.win_y_end   = y_reg + WIN_Y_SPAN;
                    out_valid_next            = 1'b1;
                    // fetch row 0 so it is ready for the first pixel
                    rom_req.rd_en             = 1'b1;
                    rom_req.row               = '0;
                    row_next                  = '0;
                    col_next                  = '0;
                    state_next                = SEQ_PIXEL;
                end
            end
            SEQ_PIXEL:
            begin
                if (out_free)
                begin
                    out_item_next             = '0;
                    out_item_next.kind        = KIND_PIXEL;
                    out_item_next.pixel_color = pix_on ? fg_color : bg_color;
                    out_item_next.last        = (row_reg == ROW_LAST) && (col_reg == COL_LAST);
                    out_valid_next            = 1'b1;
                    if (col_reg == COL_LAST)
                    begin
                        col_next = '0;
                        row_next = row_reg + 3'd1;
                        if (row_reg == ROW_LAST)
                        begin
                            state_next = SEQ_IDLE;
                        end
                        else
                        begin
                            rom_req.rd_en = 1'b1;   // next row lands with column 0
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != SEQ_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ----- design/char_glyph_pixel_renderer_top.sv -----
// Top level of the character glyph pixel renderer: config registers and wiring.
// Usage:
//   Input channel (in_valid / in_stall / in_item): one item names a character
//   code and the top-left corner of its 7x8 cell. Codes outside A-Z and 0-9
//   draw a blank cell in the background color.
//   Output channel (out_valid / out_stall / out_item): per input item, one
//   window item (kind 0, cell corners, ends wrap at 16 bits) and then 56 pixel
//   items (kind 1), row 0..7, column from glyph bit 6 down to bit 0; last is
//   set on the final pixel.
//   Config port (cfg_we / cfg_index / cfg_data): index 0 foreground color,
//   index 1 background color; other indexes are ignored. Write while idle.
// Sequencing:
//   An accepted input is captured in the idle state; the window state then
//   registers the window item and the pixel state the 56 pixel items. The
//   single output register emits one item per cycle while the output does
//   not stall, with the font memory read one row ahead. The next item is
//   taken once the last pixel is in the output register, even if that pixel
//   is still waiting.
// Reset clears the sequencer and output valid and restores the colors to
// white on black. A stall on the output freezes the sequence and its item.
module char_glyph_pixel_renderer_top
    import cgpr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [COLOR_W-1:0] fg_color_reg;
    logic [COLOR_W-1:0] bg_color_reg;
    rom_req_t           rom_req;
    logic [7:0]         rom_data;

    // Color registers; writes to unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_color_reg <= FOREGROUND_RESET;
            bg_color_reg <= BACKGROUND_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_FOREGROUND)
            begin
                fg_color_reg <= cfg_data;
            end
            else if (cfg_index == REG_BACKGROUND)
            begin
                bg_color_reg <= cfg_data;
            end
        end
    end

    // Sequencer: walks window, then rows and columns of the glyph.
    cgpr_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .fg_color  (fg_color_reg),
        .bg_color  (bg_color_reg),
        .rom_req   (rom_req),
        .rom_data  (rom_data)
    );

    // Font memory, registered read data.
    cgpr_font_rom u_font_rom (
        .clk     (clk),
        .req     (rom_req),
        .rd_data (rom_data)
    );

endmodule

// ----- tb/sv/tb_char_glyph_pixel_renderer_top.sv -----
// Self-checking testbench for the 7x8 character glyph pixel renderer.
module tb_char_glyph_pixel_renderer_top;
    import cgpr_pkg::*;

    // Colors the block wakes up with: white glyph on a black cell.
    localparam logic [COLOR_W-1:0] WHITE = 16'hFFFF;
    localparam logic [COLOR_W-1:0] BLACK = 16'h0000;

    // Font geometry and slot layout: A-Z first, then 0-9, then one empty cell.
    localparam int GLYPH_COLS  = 7;
    localparam int GLYPH_ROWS  = 8;
    localparam int DIGIT_FIRST = 26;
    localparam int EMPTY_SLOT  = 36;

    // Print at most this many mismatch lines; the count keeps going.
    localparam int MAX_PRINTED = 40;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_item_t              in_item = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_item;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the color registers as the block should hold them.
    logic [COLOR_W-1:0] fg_color = WHITE;
    logic [COLOR_W-1:0] bg_color = BLACK;

    // LCD operations (window set-up, then pixel writes) still owed by the block.
    out_item_t lcd_ops[$];

    int n_errors    = 0;
    int ops_checked = 0;

    // Idle controls: percent chance of a stall burst per cycle, of a gap per item.
    int stall_pct  = 0;
    int gap_pct    = 0;
    int stall_left = 0;
    bit calm       = 1'b0;

    always #5 clk = ~clk;

    char_glyph_pixel_renderer_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Hard stop: far beyond the slowest run (longest stall burst on every pixel).
    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic flag_error(input string msg);
        if (n_errors < MAX_PRINTED)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        n_errors++;
    endtask

    // Font rows packed MSB first: row 0 is bits 63:56, each byte uses bits 6..0.
    function automatic logic [63:0] glyph_bits(input int slot);
        case (slot)
            0:  glyph_bits = 64'h1C22_2222_3E22_2200;  // A
            1:  glyph_bits = 64'h3C22_223C_2222_3C00;  // B
            2:  glyph_bits = 64'h1C22_2020_2022_1C00;  // C
            3:  glyph_bits = 64'h3824_2222_2224_3800;  // D
            4:  glyph_bits = 64'h3E20_203C_2020_3E00;  // E
            5:  glyph_bits = 64'h3E20_203C_2020_2000;  // F
            6:  glyph_bits = 64'h1C22_202E_2222_1E00;  // G
            7:  glyph_bits = 64'h2222_223E_2222_2200;  // H
            8:  glyph_bits = 64'h1C08_0808_0808_1C00;  // I
            9:  glyph_bits = 64'h0E04_0404_0424_1800;  // J
            10: glyph_bits = 64'h2224_2830_2824_2200;  // K
            11: glyph_bits = 64'h2020_2020_2020_3E00;  // L
            12: glyph_bits = 64'h2236_2A2A_2222_2200;  // M
            13: glyph_bits = 64'h2222_322A_2622_2200;  // N
            14: glyph_bits = 64'h1C22_2222_2222_1C00;  // O
            15: glyph_bits = 64'h3C22_223C_2020_2000;  // P
            16: glyph_bits = 64'h1C22_2222_2A24_1A00;  // Q
            17: glyph_bits = 64'h3C22_223C_2824_2200;  // R
            18: glyph_bits = 64'h1E20_201C_0202_3C00;  // S
            19: glyph_bits = 64'h3E08_0808_0808_0800;  // T
            20: glyph_bits = 64'h2222_2222_2222_1C00;  // U
            21: glyph_bits = 64'h2222_2222_2214_0800;  // V
            22: glyph_bits = 64'h2222_222A_2A2A_1400;  // W
            23: glyph_bits = 64'h2222_1408_1422_2200;  // X
            24: glyph_bits = 64'h2222_2214_0808_0800;  // Y
            25: glyph_bits = 64'h3E02_0408_1020_3E00;  // Z
            26: glyph_bits = 64'h1C22_262A_3222_1C00;  // 0
            27: glyph_bits = 64'h0818_0808_0808_1C00;  // 1
            28: glyph_bits = 64'h1C22_0204_0810_3E00;  // 2
            29: glyph_bits = 64'h3E04_0804_0222_1C00;  // 3
            30: glyph_bits = 64'h040C_1424_3E04_0400;  // 4
            31: glyph_bits = 64'h3E20_3C02_0222_1C00;  // 5
            32: glyph_bits = 64'h0C10_203C_2222_1C00;  // 6
            33: glyph_bits = 64'h3E22_0204_0808_0800;  // 7
            34: glyph_bits = 64'h1C22_221C_2222_1C00;  // 8
            35: glyph_bits = 64'h1C22_221E_0204_1800;  // 9
            default: glyph_bits = 64'h0;               // empty cell
        endcase
    endfunction

    function automatic int font_slot(input logic [7:0] code);
        if (code >= "A" && code <= "Z")
            font_slot = int'(code) - int'("A");
        else if (code >= "0" && code <= "9")
            font_slot = DIGIT_FIRST + int'(code) - int'("0");
        else
            font_slot = EMPTY_SLOT;
    endfunction

    // Queue the window operation and the 56 pixel writes one character causes.
    task automatic render_char(input in_item_t item);
        out_item_t   op;
        logic [63:0] rows;
        int          r;
        int          c;
        rows = glyph_bits(font_slot(item.char_code));
        op = '0;
        op.kind        = KIND_WINDOW;
        op.win_x_start = item.x_pos;
        op.win_y_start = item.y_pos;
        op.win_x_end   = item.x_pos + 16'd6;   // wraps at 16 bits, no clipping
        op.win_y_end   = item.y_pos + 16'd7;
        lcd_ops.push_back(op);
        for (r = 0; r < GLYPH_ROWS; r++)
        begin
            for (c = 0; c < GLYPH_COLS; c++)
            begin
                op = '0;
                op.kind        = KIND_PIXEL;
                // column 0 takes glyph bit 6, column 6 takes bit 0
                op.pixel_color = rows[56 - 8 * r + 6 - c] ? fg_color : bg_color;
                op.last        = (r == GLYPH_ROWS - 1) && (c == GLYPH_COLS - 1);
                lcd_ops.push_back(op);
            end
        end
    endtask

    task automatic cmp_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
        if (got !== want)
            flag_error($sformatf("op %0d %s got %h want %h", ops_checked, name, got, want));
    endtask

    // Output side: every accepted item is matched against the oldest owed op.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (lcd_ops.size() == 0)
            begin
                flag_error($sformatf("op %0d arrived with nothing owed", ops_checked));
            end
            else
            begin
                want = lcd_ops.pop_front();
                cmp_field("kind",        16'(out_item.kind),  16'(want.kind));
                cmp_field("win_x_start", out_item.win_x_start, want.win_x_start);
                cmp_field("win_y_start", out_item.win_y_start, want.win_y_start);
                cmp_field("win_x_end",   out_item.win_x_end,   want.win_x_end);
                cmp_field("win_y_end",   out_item.win_y_end,   want.win_y_end);
                cmp_field("pixel_color", out_item.pixel_color, want.pixel_color);
                cmp_field("last",        16'(out_item.last),  16'(want.last));
            end
            ops_checked++;
        end
    end

    // Receiver back-pressure: stall bursts start at random, none when calm.
    always @(posedge clk)
    begin
        if (calm)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            stall_left = $urandom_range(0, 5);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Offer one character; returns at the edge where the block takes it.
    // Valid stays high on return so the next item can follow without a bubble.
    task automatic send_char(input logic [7:0] code, input logic [15:0] x,
                             input logic [15:0] y);
        in_item_t item;
        int       gap;
        item.char_code = code;
        item.x_pos     = x;
        item.y_pos     = y;
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        render_char(item);
    endtask

    // Drop valid and let the block drain; every item owes results, so an
    // empty queue means idle. A few spare cycles cover the output register.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (lcd_ops.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Only called while idle, so the shadow copy can follow at once.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_FOREGROUND)
            fg_color = val;
        else if (idx == REG_BACKGROUND)
            bg_color = val;
    endtask

    function automatic logic [15:0] pick_color();
        case ($urandom_range(0, 5))
            0:       pick_color = WHITE;
            1:       pick_color = BLACK;
            default: pick_color = 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // Mostly drawable characters, the rest any byte at all.
    function automatic logic [7:0] rand_code();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: rand_code = 8'("A" + $urandom_range(0, 25));
            5, 6, 7:       rand_code = 8'("0" + $urandom_range(0, 9));
            default:       rand_code = 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Positions lean toward both ends of the axis so the window end wraps often.
    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       rand_coord = 16'hFFFF - 16'($urandom_range(0, 15));
            1:       rand_coord = 16'($urandom_range(0, 15));
            default: rand_coord = 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function automatic int pct_level();
        case ($urandom_range(0, 3))
            0:       pct_level = 0;
            1:       pct_level = 10;
            2:       pct_level = 35;
            default: pct_level = 70;
        endcase
    endfunction

    // Alphabet and digit boundaries, their neighbors, lower case and byte extremes,
    // all with the reset colors.
    task automatic test_glyph_edges();
        stall_pct = 20;
        gap_pct   = 20;
        send_char("A", 16'd10, 16'd20);
        send_char("Z", 16'd17, 16'd20);
        send_char("0", 16'd24, 16'd20);
        send_char("9", 16'd31, 16'd20);
        send_char("M", 16'd38, 16'd20);
        send_char("@", 16'd45, 16'd20);     // just below A
        send_char("[", 16'd52, 16'd20);     // just above Z
        send_char("/", 16'd59, 16'd20);     // just below 0
        send_char(":", 16'd66, 16'd20);     // just above 9
        send_char("a", 16'd73, 16'd20);     // lower case draws empty
        send_char(8'h00, 16'h5555, 16'hAAAA);
        send_char(8'hFF, 16'hAAAA, 16'h5555);
    endtask

    // Window corners at both ends of the axis, including the exact wrap point.
    task automatic test_window_wrap();
        send_char("H", 16'h0000, 16'h0000);
        send_char("X", 16'hFFFF, 16'hFFFF);
        send_char("8", 16'hFFF9, 16'hFFF8);  // ends land exactly on 0xFFFF
        send_char("W", 16'hFFFA, 16'hFFF9);  // ends wrap to 0
    endtask

    task automatic test_color_regs();
        wait_idle();
        write_reg(REG_FOREGROUND, BLACK);
        write_reg(REG_BACKGROUND, WHITE);
        send_char("8", 16'd100, 16'd100);
        wait_idle();
        write_reg(REG_FOREGROUND, 16'hA5A5);
        write_reg(REG_BACKGROUND, 16'hA5A5);  // same color both ways
        send_char("W", 16'd107, 16'd100);
        wait_idle();
        write_reg(REG_FOREGROUND, 16'h5A5A);
        write_reg(REG_BACKGROUND, 16'h0F0F);
        send_char("Q", 16'd114, 16'd100);
    endtask

    // Writes to indexes past the color registers must leave both colors alone.
    task automatic test_ignored_index();
        int idx;
        wait_idle();
        for (idx = int'(REG_BACKGROUND) + 1; idx < (1 << CFG_IDX_W); idx++)
            write_reg(CFG_IDX_W'(idx), 16'($urandom_range(0, 16'hFFFF)));
        send_char("K", 16'd121, 16'd100);
        send_char("%", 16'd128, 16'd100);
    endtask

    // Ten chunks with their own stall and gap levels, colors changed between some.
    task automatic test_random_chars();
        int chunk;
        int k;
        for (chunk = 0; chunk < 10; chunk++)
        begin
            stall_pct = pct_level();
            gap_pct   = pct_level();
            if ($urandom_range(0, 2) == 0)
            begin
                wait_idle();
                write_reg(REG_FOREGROUND, pick_color());
                write_reg(REG_BACKGROUND, pick_color());
                if ($urandom_range(0, 1) == 1)
                    write_reg(CFG_IDX_W'($urandom_range(int'(REG_BACKGROUND) + 1,
                                                        (1 << CFG_IDX_W) - 1)),
                              16'($urandom_range(0, 16'hFFFF)));
            end
            for (k = 0; k < 40; k++)
                send_char(rand_code(), rand_coord(), rand_coord());
        end
    endtask

    // Closing stretch at full rate: no gaps, no stalls, characters back to back.
    task automatic test_calm_tail();
        int k;
        calm      = 1'b1;
        stall_pct = 0;
        gap_pct   = 0;
        for (k = 0; k < 40; k++)
            send_char(rand_code(), rand_coord(), rand_coord());
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_glyph_edges();
        test_window_wrap();
        test_color_regs();
        test_ignored_index();
        test_random_chars();
        test_calm_tail();

        // Everything owed has arrived; linger a little to catch stray output.
        wait_idle();
        repeat (20) @(posedge clk);

        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- char_glyph_pixel_renderer_top.f -----
design/cgpr_pkg.sv
design/cgpr_font_rom.sv
design/cgpr_seq.sv
design/char_glyph_pixel_renderer_top.sv
tb/sv/tb_char_glyph_pixel_renderer_top.sv
